### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge of clk
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/gpsut_pkg.sv
// ---------------------------------------------------------------------------
// gpsut_pkg
// constants, month table and stage type for the gps fix to unix time block
// ---------------------------------------------------------------------------
package gpsut_pkg;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned CENT_W   = 6;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 2;

  localparam logic [YEAR_W-1:0] VALID_YEAR_LIMIT = 12'd2080;
  localparam logic [YEAR_W-1:0] EPOCH_YEAR       = 12'd1970;
  localparam logic signed [12:0] DST_BASE_YEAR   = 13'sd2000;
  localparam logic [YEAR_W-1:0] LEAPS_TO_EPOCH   = 12'(1969 / 4 - 1969 / 100 + 1969 / 400);

  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_YEAR = 32'(365 * 86400);

  // reciprocal constants for division by 100 and by 7
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int unsigned SHIFT_100 = 19;
  localparam logic [13:0] RECIP_7   = 14'd9363;
  localparam int unsigned SHIFT_7   = 16;

  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [HOUR_W-1:0]  DST_HOUR  = 5'd2;
  localparam logic signed [6:0]  DST_START_DAY = 7'sd14;
  localparam logic signed [6:0]  DST_STOP_DAY  = 7'sd31;

  typedef struct packed {
    logic                      valid_fix;
    logic [YEAR_W-1:0]         year;
    logic [MONTH_W-1:0]        month;
    logic [DAY_W-1:0]          day;
    logic [HOUR_W-1:0]         hour;
    logic [MINUTE_W-1:0]       minute;
    logic [SECOND_W-1:0]       second;
    logic [CENT_W-1:0]         cent0;
    logic [CENT_W-1:0]         cent1;
    logic signed [3:0]         dst_x;
  } stage_t;

  // days in the whole months before the given count of full months
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] full);
    logic [8:0] d;
    case (full)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      4'd12:   d = 9'd365;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### design/gps_fix_to_unix_time_with_dst_top.sv
// ---------------------------------------------------------------------------
// gps_fix_to_unix_time_with_dst_top
// converts a gps fix to seconds since 1970 and tracks a daylight-saving flag
// ---------------------------------------------------------------------------
//  channel | dir | tdata                                | tuser
//  s_      | in  | year,month,day,hour,minute,second    | fix_ok
//  m_      | out | epoch_seconds                        | dst_active,time_valid
//
//  one fix per cycle sustained while m_tready is high; an accepted fix passes the input, then result register
//  the input register holds quotients by 100 and the weekday offset
//  the result register holds the second count, flag and validity
//  rst is synchronous and clears the valid bits and the daylight flag
//  m_tready low stalls the result register, then the input register
// ---------------------------------------------------------------------------
module gps_fix_to_unix_time_with_dst_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // year[11:0] month[15:12] day[20:16] hour[25:21] minute[31:26] second[37:32]
  input  logic [gpsut_pkg::IN_DATA_W-1:0]      s_tdata,
  // fix_ok[0]
  input  logic [gpsut_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // epoch_seconds[31:0]
  output logic [gpsut_pkg::OUT_DATA_W-1:0]     m_tdata,
  // dst_active[0] time_valid[1]
  output logic [gpsut_pkg::OUT_USER_W-1:0]     m_tuser
);
  import gpsut_pkg::*;

  `include "assert_macros.svh"

  stage_t st, st_next;
  logic s1_valid;
  logic out_valid;
  logic dst_flag, dst_next;
  logic adv;

  // capture side
  logic [YEAR_W-1:0]  year_in, year_in_m1;
  logic [24:0]        prod0, prod1;
  logic signed [12:0] y_off, y_mag, q4, s_sum;
  logic [11:0]        s_abs;
  logic [25:0]        prod7;
  logic [9:0]         q7;
  logic [11:0]        q7x7;
  logic [2:0]         r7;

  // result side
  logic               is_leap, after_epoch;
  logic [YEAR_W-1:0]  ym1, leaps_m1, year_days, years;
  logic [MONTH_W-1:0] full;
  logic [8:0]         month_days;
  logic [31:0]        day_sum, total;
  logic [HOUR_W:0]    hour_adj;
  logic signed [6:0]  day_s, start_d, stop_d;

  assign adv      = !out_valid || m_tready;
  assign s_tready = !s1_valid || adv;
  assign m_tvalid = out_valid;

  always_comb begin
    year_in    = s_tdata[11:0];
    year_in_m1 = year_in - 12'd1;
    prod0      = {13'd0, year_in} * {12'd0, RECIP_100};
    prod1      = {13'd0, year_in_m1} * {12'd0, RECIP_100};
    y_off      = $signed({1'b0, year_in}) - DST_BASE_YEAR;
    y_mag      = y_off[12] ? -y_off : y_off;
    q4         = y_off[12] ? -(y_mag >>> 2) : (y_mag >>> 2);
    s_sum      = y_off + q4 + 13'sd2;
    s_abs      = s_sum[12] ? 12'(-s_sum) : s_sum[11:0];
    prod7      = {14'd0, s_abs} * {12'd0, RECIP_7};
    q7         = prod7[25:SHIFT_7];
    q7x7       = {q7, 2'b00} + {1'b0, q7, 1'b0} + {2'b00, q7};
    r7         = 3'(s_abs - q7x7);

    st_next.valid_fix = s_tuser[0] && (year_in < VALID_YEAR_LIMIT);
    st_next.year      = year_in;
    st_next.month     = s_tdata[15:12];
    st_next.day       = s_tdata[20:16];
    st_next.hour      = s_tdata[25:21];
    st_next.minute    = s_tdata[31:26];
    st_next.second    = s_tdata[37:32];
    st_next.cent0     = prod0[24:SHIFT_100];
    st_next.cent1     = prod1[24:SHIFT_100];
    st_next.dst_x     = s_sum[12] ? -$signed({1'b0, r7}) : $signed({1'b0, r7});
  end

  always_comb begin
    is_leap     = (st.year[1:0] == 2'b00) && ((st.cent0 == st.cent1) || (st.cent0[1:0] == 2'b00));
    after_epoch = st.year > EPOCH_YEAR;
    ym1         = st.year - 12'd1;
    leaps_m1    = (ym1 >> 2) - {6'd0, st.cent1} + {8'd0, st.cent1[CENT_W-1:2]};
    year_days   = after_epoch ? leaps_m1 - LEAPS_TO_EPOCH : '0;
    years       = after_epoch ? st.year - EPOCH_YEAR : '0;

    if (st.month == 4'd0) begin
      full = 4'd0;
    end else if (st.month > MONTH_DEC) begin
      full = MONTH_DEC;
    end else begin
      full = st.month - 4'd1;
    end
    month_days = days_before_month(full) + {8'd0, (full >= 4'd2) && is_leap};
    day_sum    = {20'd0, year_days} + {23'd0, month_days} + {27'd0, st.day} - 32'd1;

    // daylight rule, clearing tests win
    day_s   = $signed({2'b00, st.day});
    start_d = DST_START_DAY - 7'(st.dst_x);
    stop_d  = DST_STOP_DAY - 7'(st.dst_x);
    dst_next = dst_flag;
    if (st.valid_fix) begin
      if (st.month == MONTH_MAR && day_s == start_d && st.hour >= DST_HOUR) begin
        dst_next = 1'b1;
      end
      if ((st.month == MONTH_MAR && day_s > start_d) || st.month > MONTH_MAR) begin
        dst_next = 1'b1;
      end
      if (st.month == MONTH_OCT && day_s == stop_d && st.hour >= DST_HOUR) begin
        dst_next = 1'b0;
      end
      if ((st.month == MONTH_OCT && day_s > stop_d) || st.month > MONTH_OCT ||
          st.month < MONTH_MAR) begin
        dst_next = 1'b0;
      end
    end else begin
      dst_next = 1'b0;
    end

    hour_adj = {1'b0, st.hour} + {5'd0, dst_next};
    total    = {20'd0, years} * SECS_PER_YEAR
             + day_sum * SECS_PER_DAY
             + {26'd0, hour_adj} * SECS_PER_HOUR
             + {26'd0, st.minute} * SECS_PER_MIN
             + {26'd0, st.second};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      dst_flag  <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
      if (adv && s1_valid) begin
        dst_flag <= dst_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      st <= st_next;
    end
    if (adv && s1_valid) begin
      m_tdata <= total;
      m_tuser <= {st.valid_fix, dst_next};
    end
  end

  `ASSERT_IMPL(a_invalid_no_dst, out_valid && !m_tuser[1], !m_tuser[0], "dst set on invalid fix")
  `ASSERT_IMPL(a_flag_matches_out, out_valid, dst_flag == m_tuser[0], "flag differs from result")
  `ASSERT_NEXT(a_winter_clears, s1_valid && adv && st.valid_fix && st.month < MONTH_MAR, !dst_flag, "flag not cleared before march")
  `ASSERT_IMPL(a_stall_only_full, !s_tready, s1_valid && out_valid, "input stalled with room")

endmodule

### dv/gps_fix_to_unix_time_with_dst_top_tb.sv
// ---------------------------------------------------------------------------
// gps_fix_to_unix_time_with_dst_top_tb
// self-checking bench for the gps fix to unix time block: a directed table of
// fixes around the daylight-saving edges and field extremes, then random
// fixes, each result checked against a typed table value or an in-bench model
// of the seconds count, the daylight flag and the validity, with random idling
// on both channels
module gps_fix_to_unix_time_with_dst_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpsut_pkg::*;

  localparam int unsigned N_DIR      = 25;
  localparam int unsigned N_RAND     = 1000;
  localparam int unsigned N_QUIET    = 100;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned DRAIN_WAIT = 8;
  localparam int unsigned MAX_SHOWN  = 40;

  typedef struct {
    logic                fix_ok;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } fix_t;

  typedef struct {
    logic [31:0] epoch;
    logic        dst;
    logic        valid;
  } unix_time_t;

  typedef struct {
    int          fix_ok;
    int          year;
    int          month;
    int          day;
    int          hour;
    int          minute;
    int          second;
    bit          typed;
    logic [31:0] epoch;
    logic        dst;
    logic        valid;
  } fix_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [IN_USER_W-1:0]  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  unix_time_t  expected_times [$];
  logic        dst_model;
  int unsigned error_count;
  int unsigned cycle_count;
  bit          idle_mode;

  const int unsigned month_offset [13] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

  const fix_row_t fix_rows [N_DIR] = '{
    '{0, 1970, 1, 1, 0, 0, 0, 1, 32'd0, 1'b0, 1'b0},
    '{1, 1970, 1, 1, 0, 0, 0, 1, 32'd0, 1'b0, 1'b1},
    '{1, 2000, 1, 1, 0, 0, 0, 1, 32'd946684800, 1'b0, 1'b1},
    '{0, 0, 0, 0, 0, 0, 0, 1, 32'hFFFEAE80, 1'b0, 1'b0},
    '{1, 2079, 12, 31, 23, 59, 59, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 3, 10, 1, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 3, 10, 2, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 10, 27, 1, 30, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 10, 27, 2, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 3, 11, 0, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 10, 28, 0, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 4, 1, 0, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 11, 1, 0, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 7, 4, 12, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 2, 29, 12, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 7, 4, 12, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{0, 2024, 7, 4, 12, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2024, 7, 4, 12, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2080, 7, 4, 12, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 1999, 3, 13, 2, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 1960, 3, 20, 3, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2023, 13, 5, 6, 7, 8, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2023, 15, 31, 31, 63, 63, 0, 32'd0, 1'b0, 1'b0},
    '{1, 2023, 0, 0, 0, 0, 0, 0, 32'd0, 1'b0, 1'b0},
    '{1, 4095, 15, 31, 31, 63, 63, 0, 32'd0, 1'b0, 1'b0}
  };

  gps_fix_to_unix_time_with_dst_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // seconds since 1970 for one fix, advancing the daylight flag
  function automatic unix_time_t unix_time_of_fix(input fix_t f);
    unix_time_t  r;
    int          yr_off;
    int          x_off;
    int          start_day;
    int          stop_day;
    int          mon;
    int          dy;
    int unsigned yv;
    int unsigned full;
    logic        leap;
    logic [63:0] days;
    logic [63:0] total;
    r.valid = f.fix_ok && (f.year < VALID_YEAR_LIMIT);
    if (r.valid) begin
      yr_off    = int'(f.year) - int'(DST_BASE_YEAR);
      x_off     = (yr_off + yr_off / 4 + 2) % 7;
      start_day = int'(DST_START_DAY) - x_off;
      stop_day  = int'(DST_STOP_DAY) - x_off;
      mon       = int'(f.month);
      dy        = int'(f.day);
      if (mon == int'(MONTH_MAR) && dy == start_day && f.hour >= DST_HOUR) begin
        dst_model = 1'b1;
      end
      if ((mon == int'(MONTH_MAR) && dy > start_day) || mon > int'(MONTH_MAR)) begin
        dst_model = 1'b1;
      end
      if (mon == int'(MONTH_OCT) && dy == stop_day && f.hour >= DST_HOUR) begin
        dst_model = 1'b0;
      end
      if ((mon == int'(MONTH_OCT) && dy > stop_day) || mon > int'(MONTH_OCT) ||
          mon < int'(MONTH_MAR)) begin
        dst_model = 1'b0;
      end
    end else begin
      dst_model = 1'b0;
    end
    yv = 32'(f.year);
    if (yv <= EPOCH_YEAR) begin
      days = 64'd0;
    end else begin
      days = 64'(365 * (yv - EPOCH_YEAR))
           + 64'((yv - 1) / 4 - (yv - 1) / 100 + (yv - 1) / 400 - LEAPS_TO_EPOCH);
    end
    if (f.month == 0) begin
      full = 0;
    end else if (f.month > MONTH_DEC) begin
      full = 12;
    end else begin
      full = 32'(f.month) - 1;
    end
    leap = (yv % 4 == 0) && ((yv % 100 != 0) || (yv % 400 == 0));
    days = days + 64'(month_offset[full]) + ((full >= 2 && leap) ? 64'd1 : 64'd0)
         + 64'(f.day);
    total = days * SECS_PER_DAY - SECS_PER_DAY
          + (64'(f.hour) + 64'(dst_model)) * SECS_PER_HOUR
          + 64'(f.minute) * SECS_PER_MIN
          + 64'(f.second);
    r.epoch = total[31:0];
    r.dst   = dst_model;
    return r;
  endfunction

  function automatic fix_t random_fix();
    fix_t        f;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // mostly valid fixes clustered around the march and october edges
      f.fix_ok = ($urandom_range(0, 15) != 0);
      f.year   = 12'($urandom_range(2000, 2079));
      case ($urandom_range(0, 3))
        0:       f.month = MONTH_MAR;
        1:       f.month = MONTH_OCT;
        default: f.month = 4'($urandom_range(1, 12));
      endcase
      if (f.month == MONTH_MAR) begin
        f.day = 5'($urandom_range(7, 16));
      end else if (f.month == MONTH_OCT) begin
        f.day = 5'($urandom_range(24, 31));
      end else begin
        f.day = 5'($urandom_range(1, 31));
      end
      f.hour = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(1, 2))
                                           : 5'($urandom_range(0, 23));
    end else if (pick < 85) begin
      f.fix_ok = 1'($urandom_range(0, 1));
      f.year   = 12'($urandom_range(2000, 2099));
      f.month  = 4'($urandom_range(1, 12));
      f.day    = 5'($urandom_range(1, 31));
      f.hour   = 5'($urandom_range(0, 23));
    end else begin
      f.fix_ok = 1'($urandom);
      f.year   = 12'($urandom);
      f.month  = 4'($urandom);
      f.day    = 5'($urandom);
      f.hour   = 5'($urandom);
      f.minute = 6'($urandom);
      f.second = 6'($urandom);
      return f;
    end
    f.minute = 6'($urandom_range(0, 59));
    f.second = 6'($urandom_range(0, 59));
    return f;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  // one fix transaction, entered and left at a falling edge
  task automatic send_fix(input fix_t f, input bit typed, input unix_time_t typed_res);
    unix_time_t predicted;
    if (idle_mode && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {2'b00, f.second, f.minute, f.hour, f.day, f.month, f.year};
    s_tuser  = f.fix_ok;
    do @(posedge clk); while (!s_tready);
    predicted = unix_time_of_fix(f);
    if (typed) begin
      expected_times.push_back(typed_res);
    end else begin
      expected_times.push_back(predicted);
    end
    @(negedge clk);
  endtask

  initial begin
    fix_t       f;
    unix_time_t typed_res;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    dst_model = 1'b0;
    idle_mode = 1'b1;
    error_count = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (fix_rows[i]) begin
      f.fix_ok = 1'(fix_rows[i].fix_ok);
      f.year   = 12'(fix_rows[i].year);
      f.month  = 4'(fix_rows[i].month);
      f.day    = 5'(fix_rows[i].day);
      f.hour   = 5'(fix_rows[i].hour);
      f.minute = 6'(fix_rows[i].minute);
      f.second = 6'(fix_rows[i].second);
      typed_res.epoch = fix_rows[i].epoch;
      typed_res.dst   = fix_rows[i].dst;
      typed_res.valid = fix_rows[i].valid;
      send_fix(f, fix_rows[i].typed, typed_res);
    end
    for (int unsigned n = 0; n < N_RAND; n++) begin
      if (n >= N_RAND - N_QUIET) begin
        idle_mode = 1'b0;
      end else if (n % 64 == 0) begin
        idle_mode = ($urandom_range(0, 3) != 0);
      end
      if (n == N_RAND / 2) begin
        s_tvalid = 1'b0;
        while (expected_times.size() != 0) @(negedge clk);
      end
      send_fix(random_fix(), 1'b0, typed_res);
    end
    s_tvalid = 1'b0;
    while (expected_times.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int unsigned stall_left;
    m_tready   = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (idle_mode && stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    unix_time_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_times.size() == 0) begin
        report_mismatch($sformatf("result with none expected: %0d", m_tdata));
      end else begin
        exp_res = expected_times.pop_front();
        if (m_tdata !== exp_res.epoch) begin
          report_mismatch($sformatf("epoch_seconds got %0d expected %0d",
                                    m_tdata, exp_res.epoch));
        end
        if (m_tuser[0] !== exp_res.dst) begin
          report_mismatch($sformatf("dst_active got %b expected %b",
                                    m_tuser[0], exp_res.dst));
        end
        if (m_tuser[1] !== exp_res.valid) begin
          report_mismatch($sformatf("time_valid got %b expected %b",
                                    m_tuser[1], exp_res.valid));
        end
      end
    end
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

### filelist.f
+incdir+design
design/gpsut_pkg.sv
design/gps_fix_to_unix_time_with_dst_top.sv
dv/gps_fix_to_unix_time_with_dst_top_tb.sv
